FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the date midpoint RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

FILE: rtl/gdm_pkg.sv
// ----------------------------------------------------------------------------
// gdm_pkg
// Types, opcodes and calendar helpers shared by the date midpoint unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gdm_pkg;

    localparam int SER_W = 22;
    localparam int PC_W  = 5;

    localparam logic [15:0] MAX_YEAR  = 16'd9999;
    localparam logic [8:0]  DAYS_YEAR = 9'd365;

    // Datapath operations
    localparam logic [3:0] OP_NOP    = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_SETYR  = 4'd2;
    localparam logic [3:0] OP_BASE   = 4'd3;
    localparam logic [3:0] OP_MODS   = 4'd4;
    localparam logic [3:0] OP_DOY    = 4'd5;
    localparam logic [3:0] OP_DIFF   = 4'd6;
    localparam logic [3:0] OP_HALF   = 4'd7;
    localparam logic [3:0] OP_YSTEP  = 4'd8;
    localparam logic [3:0] OP_MINIT  = 4'd9;
    localparam logic [3:0] OP_MSTEP  = 4'd10;
    localparam logic [3:0] OP_OUT    = 4'd11;
    localparam logic [3:0] OP_ERROUT = 4'd12;

    // Sequencer branch conditions
    localparam logic [2:0] C_NEXT     = 3'd0;
    localparam logic [2:0] C_JUMP     = 3'd1;
    localparam logic [2:0] C_BAD      = 3'd2;
    localparam logic [2:0] C_LOOP     = 3'd3;
    localparam logic [2:0] C_HOLD_IN  = 3'd4;
    localparam logic [2:0] C_HOLD_OUT = 3'd5;

    typedef struct packed {
        logic [3:0]      op;
        logic            sel;     // 0 selects the start date, 1 the end date
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        logic in_go;
        logic bad;
        logic more;
        logic out_go;
    } seq_status_t;

    // Floor of v / 25 by reciprocal multiply; the estimate is low by at most one.
    function automatic logic [11:0] div25(input logic [15:0] v);
        logic [28:0] prod;
        logic [11:0] q;
        logic [15:0] r;
        prod = 29'(v) * 29'd5242;
        q    = prod[28:17];
        r    = v - 16'(q) * 16'd25;
        if (r >= 16'd25)
            q = q + 12'd1;
        return q;
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m)
            4'd2:                         d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:      d = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
            4'd10, 4'd12:                 d = 5'd31;
            default:                      d = 5'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/gdm_seq.sv
// ----------------------------------------------------------------------------
// gdm_seq
// Microcode sequencer: step counter, control store and branch logic.
// ----------------------------------------------------------------------------
`default_nettype none

module gdm_seq (
    input  logic                     clk,
    input  logic                     rst_n,
    input  gdm_pkg::seq_status_t     status,
    output gdm_pkg::ctrl_word_t      cw
);
    import gdm_pkg::*;

    localparam logic [PC_W-1:0] PC_WAIT  = 5'd0;
    localparam logic [PC_W-1:0] PC_YLOOP = 5'd17;
    localparam logic [PC_W-1:0] PC_MLOOP = 5'd19;
    localparam logic [PC_W-1:0] PC_ERR   = 5'd21;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic [PC_W-1:0] pc_inc;

    function automatic ctrl_word_t mk(input logic [3:0] op, input logic sel,
                                      input logic [2:0] cond,
                                      input logic [PC_W-1:0] target);
        ctrl_word_t w;
        w.op     = op;
        w.sel    = sel;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // Each date takes six steps: base serial of the previous year, then the
    // day of year with the leap test taken from the mod counters.
    function automatic ctrl_word_t rom(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        unique case (pc)
            5'd0:    w = mk(OP_LOAD,   1'b0, C_HOLD_IN,  PC_WAIT);
            5'd1:    w = mk(OP_SETYR,  1'b0, C_NEXT,     PC_WAIT);
            5'd2:    w = mk(OP_NOP,    1'b0, C_NEXT,     PC_WAIT);
            5'd3:    w = mk(OP_BASE,   1'b0, C_NEXT,     PC_WAIT);
            5'd4:    w = mk(OP_NOP,    1'b0, C_NEXT,     PC_WAIT);
            5'd5:    w = mk(OP_MODS,   1'b0, C_NEXT,     PC_WAIT);
            5'd6:    w = mk(OP_DOY,    1'b0, C_NEXT,     PC_WAIT);
            5'd7:    w = mk(OP_SETYR,  1'b1, C_NEXT,     PC_WAIT);
            5'd8:    w = mk(OP_NOP,    1'b1, C_NEXT,     PC_WAIT);
            5'd9:    w = mk(OP_BASE,   1'b1, C_NEXT,     PC_WAIT);
            5'd10:   w = mk(OP_NOP,    1'b1, C_NEXT,     PC_WAIT);
            5'd11:   w = mk(OP_MODS,   1'b1, C_NEXT,     PC_WAIT);
            5'd12:   w = mk(OP_DOY,    1'b1, C_NEXT,     PC_WAIT);
            5'd13:   w = mk(OP_DIFF,   1'b0, C_BAD,      PC_ERR);
            5'd14:   w = mk(OP_HALF,   1'b0, C_NEXT,     PC_WAIT);
            5'd15:   w = mk(OP_NOP,    1'b0, C_NEXT,     PC_WAIT);
            5'd16:   w = mk(OP_MODS,   1'b0, C_NEXT,     PC_WAIT);
            5'd17:   w = mk(OP_YSTEP,  1'b0, C_LOOP,     PC_YLOOP);
            5'd18:   w = mk(OP_MINIT,  1'b0, C_NEXT,     PC_WAIT);
            5'd19:   w = mk(OP_MSTEP,  1'b0, C_LOOP,     PC_MLOOP);
            5'd20:   w = mk(OP_OUT,    1'b0, C_HOLD_OUT, PC_WAIT);
            5'd21:   w = mk(OP_ERROUT, 1'b0, C_HOLD_OUT, PC_WAIT);
            default: w = mk(OP_NOP,    1'b0, C_JUMP,     PC_WAIT);
        endcase
        return w;
    endfunction

    assign cw     = rom(pc_reg);
    assign pc_inc = pc_reg + 5'd1;

    always_comb
    begin
        unique case (cw.cond)
            C_NEXT:     pc_next = pc_inc;
            C_JUMP:     pc_next = cw.target;
            C_BAD:      pc_next = status.bad ? cw.target : pc_inc;
            C_LOOP:     pc_next = status.more ? cw.target : pc_inc;
            C_HOLD_IN:  pc_next = status.in_go ? pc_inc : pc_reg;
            C_HOLD_OUT: pc_next = status.out_go ? cw.target : pc_reg;
            default:    pc_next = PC_WAIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= PC_WAIT;
        else
            pc_reg <= pc_next;
    end

endmodule

`default_nettype wire

FILE: rtl/gregorian_date_midpoint_unit.sv
// Throughput: one word at a time; a new word is taken only once the result of
// the last one has gone into the output register. The year walk steps one
// year per cycle.
// Reset: asynchronous active low; the step counter returns to the wait step
// and the output register empties.
// ----------------------------------------------------------------------------
// gregorian_date_midpoint_unit
// Midpoint of two Gregorian dates with half-day flag, run by a microcoded
// sequencer over a small serial-number and calendar-walk datapath.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gregorian_date_midpoint_unit #(
    parameter int YEAR_BITS = 14
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // start_day, start_month, start_year, end_day, end_month, end_year
    input  logic [((18 + 2 * YEAR_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // mid_day, mid_month, mid_year, half_day, bad_dates
    output logic [((11 + YEAR_BITS + 7) / 8) * 8 - 1:0]     m_axis_tdata
);
    import gdm_pkg::*;

    localparam int YW    = YEAR_BITS;
    localparam int OUT_W = ((11 + YW + 7) / 8) * 8;
    localparam int SM_LO = 5;
    localparam int SY_LO = 9;
    localparam int ED_LO = 9 + YW;
    localparam int EM_LO = 14 + YW;
    localparam int EY_LO = 18 + YW;

    ctrl_word_t  cw;
    seq_status_t st;

    logic [4:0]       sd_reg, ed_reg;
    logic [3:0]       sm_reg, em_reg;
    logic [YW-1:0]    sy_reg, ey_reg;
    logic [YW-1:0]    yr_reg;
    logic [3:0]       mo_reg;
    logic [11:0]      q100_reg, q400_reg;
    logic [1:0]       c4_reg;
    logic [6:0]       c100_reg;
    logic [8:0]       c400_reg;
    logic [SER_W-1:0] acc_reg, sa_reg, sb_reg, diff_reg;
    logic [8:0]       doy_reg;
    logic             bad_reg;

    logic             out_valid_reg;
    logic [4:0]       od_reg;
    logic [3:0]       om_reg;
    logic [YW-1:0]    oy_reg;
    logic             ohalf_reg, obad_reg;

    logic [4:0]       d_sel;
    logic [3:0]       m_sel;
    logic [YW-1:0]    y_sel;
    logic [15:0]      yr16;
    logic [6:0]       m100;
    logic [8:0]       m400;
    logic             leap;
    logic [8:0]       ylen;
    logic [4:0]       mlen;
    logic [8:0]       doy;
    logic             date_bad;
    logic [SER_W-1:0] base_val;
    logic             year_more, month_more;

    gdm_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (st),
        .cw     (cw)
    );

    assign s_axis_tready = (cw.op == OP_LOAD);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({obad_reg, ohalf_reg, oy_reg, om_reg, od_reg});

    assign d_sel = cw.sel ? ed_reg : sd_reg;
    assign m_sel = cw.sel ? em_reg : sm_reg;
    assign y_sel = cw.sel ? ey_reg : sy_reg;
    assign yr16  = 16'(yr_reg);

    assign m100 = 7'(yr16 - 16'(q100_reg) * 16'd100);
    assign m400 = 9'(yr16 - 16'(q400_reg) * 16'd400);

    // The mod counters follow yr_reg, so the leap test needs no divider in the walk.
    assign leap = ((c4_reg == 2'd0) && (c100_reg != 7'd0)) || (c400_reg == 9'd0);
    assign ylen = DAYS_YEAR + 9'(leap);
    assign mlen = month_days(mo_reg, leap);

    assign doy = days_before(m_sel) + 9'((m_sel > 4'd2) && leap) + 9'(d_sel) - 9'd1;
    assign date_bad = (m_sel == 4'd0) || (m_sel > 4'd12) || (yr16 == 16'd0) ||
                      (yr16 > MAX_YEAR) || (d_sel == 5'd0) ||
                      (d_sel > month_days(m_sel, leap));

    // Days before January 1 of year yr_reg + 1, with yr_reg holding the previous year.
    assign base_val = SER_W'(yr16) * SER_W'(DAYS_YEAR) + SER_W'(yr16 >> 2)
                      - SER_W'(q100_reg) + SER_W'(q400_reg);

    assign year_more  = (acc_reg >= SER_W'(ylen));
    assign month_more = (mo_reg < 4'd12) && (acc_reg >= SER_W'(mlen));

    assign st.in_go  = s_axis_tvalid && s_axis_tready;
    assign st.bad    = bad_reg || (sb_reg < sa_reg);
    assign st.more   = (cw.op == OP_YSTEP) ? year_more : month_more;
    assign st.out_go = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk)
    begin
        q100_reg <= div25(yr16 >> 2);
        q400_reg <= div25(yr16 >> 4);
        unique case (cw.op)
            OP_LOAD:
            begin
                if (st.in_go)
                begin
                    sd_reg  <= s_axis_tdata[4:0];
                    sm_reg  <= s_axis_tdata[SM_LO +: 4];
                    sy_reg  <= s_axis_tdata[SY_LO +: YW];
                    ed_reg  <= s_axis_tdata[ED_LO +: 5];
                    em_reg  <= s_axis_tdata[EM_LO +: 4];
                    ey_reg  <= s_axis_tdata[EY_LO +: YW];
                    bad_reg <= 1'b0;
                end
            end
            OP_SETYR:
                yr_reg <= y_sel - YW'(1);
            OP_BASE:
            begin
                acc_reg <= base_val;
                yr_reg  <= y_sel;
            end
            OP_MODS:
            begin
                c4_reg   <= yr_reg[1:0];
                c100_reg <= m100;
                c400_reg <= m400;
            end
            OP_DOY:
            begin
                if (date_bad)
                    bad_reg <= 1'b1;
                if (cw.sel)
                    sb_reg <= acc_reg + SER_W'(doy);
                else
                begin
                    sa_reg  <= acc_reg + SER_W'(doy);
                    doy_reg <= doy;
                end
            end
            OP_DIFF:
                diff_reg <= sb_reg - sa_reg;
            OP_HALF:
            begin
                // Offset of the midpoint from January 1 of the start year.
                acc_reg <= SER_W'(doy_reg) + (diff_reg >> 1);
                yr_reg  <= sy_reg;
            end
            OP_YSTEP:
            begin
                if (year_more)
                begin
                    acc_reg  <= acc_reg - SER_W'(ylen);
                    yr_reg   <= yr_reg + YW'(1);
                    c4_reg   <= c4_reg + 2'd1;
                    c100_reg <= (c100_reg == 7'd99) ? 7'd0 : c100_reg + 7'd1;
                    c400_reg <= (c400_reg == 9'd399) ? 9'd0 : c400_reg + 9'd1;
                end
            end
            OP_MINIT:
                mo_reg <= 4'd1;
            OP_MSTEP:
            begin
                if (month_more)
                begin
                    acc_reg <= acc_reg - SER_W'(mlen);
                    mo_reg  <= mo_reg + 4'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (((cw.op == OP_OUT) || (cw.op == OP_ERROUT)) && st.out_go)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (st.out_go && (cw.op == OP_OUT))
        begin
            od_reg    <= 5'(acc_reg + SER_W'(1));
            om_reg    <= mo_reg;
            oy_reg    <= yr_reg;
            ohalf_reg <= diff_reg[0];
            obad_reg  <= 1'b0;
        end
        else if (st.out_go && (cw.op == OP_ERROUT))
        begin
            od_reg    <= 5'd0;
            om_reg    <= 4'd0;
            oy_reg    <= '0;
            ohalf_reg <= 1'b0;
            obad_reg  <= 1'b1;
        end
    end

    `ASSERT_IMPL(a_walk_bound, clk, rst_n, cw.op == OP_YSTEP, yr_reg <= ey_reg)
    `ASSERT_IMPL(a_bad_zero, clk, rst_n, out_valid_reg && obad_reg, (od_reg == 5'd0) && (om_reg == 4'd0) && (oy_reg == '0) && !ohalf_reg)
    `ASSERT_IMPL(a_good_range, clk, rst_n, out_valid_reg && !obad_reg, (od_reg != 5'd0) && (om_reg != 4'd0) && (om_reg <= 4'd12))
    `ASSERT_NEXT(a_one_item, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Date midpoint unit testbench
// Sends pairs of Gregorian dates over the input stream and checks each
// midpoint word against a day-number calendar computed here: directed edge
// dates first, then random ordered, reversed, wide-span and malformed pairs,
// with random gaps on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int YB     = 14;
    localparam int IN_W   = ((18 + 2 * YB + 7) / 8) * 8;
    localparam int OUT_W  = ((11 + YB + 7) / 8) * 8;
    localparam int LAST_Y = 9999;

    typedef struct {
        logic [4:0]    day;
        logic [3:0]    month;
        logic [YB-1:0] year;
    } cal_date_t;

    typedef struct {
        cal_date_t start_date;
        cal_date_t end_date;
    } date_pair_t;

    typedef struct {
        logic [4:0]    day;
        logic [3:0]    month;
        logic [YB-1:0] year;
        logic          half;
        logic          bad;
    } midpoint_t;

    class midpoint_scoreboard;
        midpoint_t   pending[$];
        int          errors;
        // Last valid request, with the span cut to the block's 22-bit serial width.
        int unsigned span_days;
        midpoint_t   last_mid;

        function new();
            errors = 0;
            span_days = 0;
            last_mid = '{day: 5'd1, month: 4'd1, year: YB'(1), half: 1'b0, bad: 1'b0};
        endfunction

        function bit leap_year(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function int unsigned month_length(int unsigned m, int unsigned y);
            case (m)
                2:             return leap_year(y) ? 29 : 28;
                4, 6, 9, 11:   return 30;
                default:       return 31;
            endcase
        endfunction

        function bit date_ok(cal_date_t d);
            if (d.month < 1 || d.month > 12 || d.year < 1 || d.year > LAST_Y)
                return 1'b0;
            return d.day >= 1 && d.day <= month_length(d.month, d.year);
        endfunction

        // Days elapsed since 1 January of year 1.
        function int unsigned day_number(cal_date_t d);
            int unsigned p;
            int unsigned s;
            p = d.year - 1;
            s = 365 * p + p / 4 - p / 100 + p / 400;
            for (int unsigned k = 1; k < d.month; k++)
                s += month_length(k, d.year);
            return s + d.day - 1;
        endfunction

        function cal_date_t date_of(int unsigned s);
            cal_date_t   d;
            int unsigned r;
            int unsigned q400;
            int unsigned q100;
            int unsigned q4;
            int unsigned q1;
            int unsigned y;
            int unsigned m;
            q400 = s / 146097;
            r    = s % 146097;
            q100 = r / 36524;
            if (q100 > 3)
                q100 = 3;
            r  -= q100 * 36524;
            q4  = r / 1461;
            r  -= q4 * 1461;
            q1  = r / 365;
            // The last day of a four-year or 400-year block belongs to its last year.
            if (q1 > 3)
                q1 = 3;
            r -= q1 * 365;
            y = 400 * q400 + 100 * q100 + 4 * q4 + q1 + 1;
            m = 1;
            while (m < 12 && r >= month_length(m, y))
            begin
                r -= month_length(m, y);
                m++;
            end
            d.day   = 5'(r + 1);
            d.month = 4'(m);
            d.year  = YB'(y);
            return d;
        endfunction

        function void note_request(date_pair_t p);
            midpoint_t   mid;
            cal_date_t   md;
            int unsigned s0;
            int unsigned s1;
            mid = '{day: 5'd0, month: 4'd0, year: '0, half: 1'b0, bad: 1'b1};
            if (date_ok(p.start_date) && date_ok(p.end_date))
            begin
                s0 = day_number(p.start_date);
                s1 = day_number(p.end_date);
                if (s1 >= s0)
                begin
                    md = date_of(s0 + (s1 - s0) / 2);
                    mid = '{day: md.day, month: md.month, year: md.year,
                            half: 1'((s1 - s0) % 2), bad: 1'b0};
                    span_days = (s1 - s0) & 32'h3F_FFFF;
                    last_mid = mid;
                end
            end
            pending.push_back(mid);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(midpoint_t got);
            midpoint_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word, expected none actual %0d-%0d-%0d",
                         $time, got.year, got.month, got.day);
                return;
            end
            want = pending.pop_front();
            compare_field("mid_day", want.day, got.day);
            compare_field("mid_month", want.month, got.month);
            compare_field("mid_year", want.year, got.year);
            compare_field("half_day", want.half, got.half);
            compare_field("bad_dates", want.bad, got.bad);
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             quiet = 1'b0;

    midpoint_scoreboard board;

    gregorian_date_midpoint_unit #(
        .YEAR_BITS(YB)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic date_pair_t pair_of(int sd, int sm, int sy, int ed, int em, int ey);
        date_pair_t p;
        p.start_date = '{day: 5'(sd), month: 4'(sm), year: YB'(sy)};
        p.end_date   = '{day: 5'(ed), month: 4'(em), year: YB'(ey)};
        return p;
    endfunction

    function automatic cal_date_t random_date_in(int unsigned y);
        cal_date_t   d;
        int unsigned len;
        d.year  = YB'(y);
        d.month = 4'($urandom_range(1, 12));
        len     = board.month_length(d.month, y);
        // Month ends are where the walks turn over, so they get extra weight.
        d.day   = ($urandom_range(99) < 15) ? 5'(len) : 5'($urandom_range(1, len));
        return d;
    endfunction

    // Result sink: check on the accepting edge, then pick the next ready.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result('{day: m_axis_tdata[4:0], month: m_axis_tdata[8:5],
                                 year: m_axis_tdata[9 +: YB], half: m_axis_tdata[YB + 9],
                                 bad: m_axis_tdata[YB + 10]});
        m_axis_tready <= rst_n && (quiet || $urandom_range(99) >= 22);
    end

    task automatic send_pair(input date_pair_t p);
        while (!quiet && $urandom_range(99) < 22)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({p.end_date.year, p.end_date.month, p.end_date.day,
                                p.start_date.year, p.start_date.month, p.start_date.day});
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_request(p);
    endtask

    initial
    begin
        date_pair_t  p;
        date_pair_t  directed[$];
        cal_date_t   swap;
        int unsigned r;
        int unsigned sy;
        int unsigned ey;

        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed.push_back(pair_of(1, 1, 1, 1, 1, 1));              // equal dates
        directed.push_back(pair_of(31, 12, 9999, 31, 12, 9999));
        directed.push_back(pair_of(1, 1, 1, 31, 12, 9999));         // widest span
        directed.push_back(pair_of(28, 2, 2023, 1, 3, 2023));       // odd count
        directed.push_back(pair_of(29, 2, 2024, 1, 3, 2024));       // leap day
        directed.push_back(pair_of(29, 2, 2023, 1, 3, 2023));       // no leap day
        directed.push_back(pair_of(29, 2, 1900, 1, 3, 1900));       // century, common
        directed.push_back(pair_of(1, 1, 2000, 29, 2, 2000));       // 400-year leap
        directed.push_back(pair_of(2, 1, 2000, 1, 1, 2000));        // end before start
        directed.push_back(pair_of(1, 1, 2001, 31, 12, 2000));
        directed.push_back(pair_of(1, 0, 2000, 1, 1, 2001));        // month zero
        directed.push_back(pair_of(1, 13, 2000, 1, 1, 2001));
        directed.push_back(pair_of(1, 1, 2000, 1, 15, 2001));
        directed.push_back(pair_of(0, 1, 2000, 1, 1, 2001));        // day zero
        directed.push_back(pair_of(31, 4, 2000, 1, 5, 2000));       // day past month end
        directed.push_back(pair_of(1, 1, 0, 1, 1, 5));              // year zero
        directed.push_back(pair_of(1, 1, 9999, 1, 1, 10000));
        directed.push_back(pair_of(31, 15, 16383, 31, 15, 16383));  // all ones
        directed.push_back(pair_of(31, 12, 1999, 1, 1, 2001));
        directed.push_back(pair_of(15, 3, 2021, 20, 11, 2021));
        directed.push_back(pair_of(31, 1, 1600, 31, 12, 1600));
        directed.push_back(pair_of(28, 2, 2100, 1, 3, 2100));
        foreach (directed[i])
            send_pair(directed[i]);

        for (int i = 0; i < 78; i++)
        begin
            quiet <= (i >= 40 && i < 70);
            r = $urandom_range(99);
            if (r < 12)
            begin
                p = pair_of($urandom_range(0, 31), $urandom_range(0, 15),
                            $urandom_range(0, (1 << YB) - 1), $urandom_range(0, 31),
                            $urandom_range(0, 15), $urandom_range(0, (1 << YB) - 1));
            end
            else
            begin
                sy = $urandom_range(1, LAST_Y);
                // A few spans reach across millennia; most stay within a few years.
                ey = sy + ((r < 22) ? $urandom_range(0, LAST_Y) : $urandom_range(0, 4));
                if (ey > LAST_Y)
                    ey = LAST_Y;
                p.start_date = random_date_in(sy);
                p.end_date   = random_date_in(ey);
                if ((board.day_number(p.end_date) < board.day_number(p.start_date))
                    != (r >= 22 && r < 30))
                begin
                    swap = p.start_date;
                    p.start_date = p.end_date;
                    p.end_date = swap;
                end
            end
            send_pair(p);
        end
        s_axis_tvalid <= 1'b0;
        quiet <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
